/* src/tsm_pkg.sv */
// Shared constants, command/status types and character helpers for the name matcher.
`default_nettype none
package tsm_pkg;

  // Template store geometry (depth is a power of two)
  localparam int TMPL_DEPTH = 64;
  localparam int TMPL_AW    = $clog2(TMPL_DEPTH);
  // Width of a clamped length or a template position (0..TMPL_DEPTH, plus headroom)
  localparam int CLEN_W     = $clog2(TMPL_DEPTH + 2);
  // Width of the configuration length registers
  localparam int CFG_W      = 7;

  // Configuration register indexes
  localparam logic CFG_PREFIX_LEN   = 1'b0;
  localparam logic CFG_TEMPLATE_LEN = 1'b1;

  // Input item kinds
  localparam logic KIND_TMPL_WR = 1'b0;
  localparam logic KIND_NAME    = 1'b1;

  // Characters of interest
  localparam logic [7:0] CH_PCT  = 8'h25;  // '%'
  localparam logic [7:0] CH_DOT  = 8'h2E;  // '.'
  localparam logic [7:0] CH_7    = 8'h37;  // '7'
  localparam logic [7:0] CH_Z    = 8'h7A;  // 'z'
  localparam logic [7:0] CH_0    = 8'h30;  // '0'
  localparam logic [7:0] CH_9    = 8'h39;  // '9'
  localparam logic [7:0] CH_UY   = 8'h59;  // 'Y'
  localparam logic [7:0] CH_LJ   = 8'h6A;  // 'j'
  localparam logic [7:0] CH_UC   = 8'h43;  // 'C'
  localparam logic [7:0] CH_LD   = 8'h64;  // 'd'
  localparam logic [7:0] CH_LE   = 8'h65;  // 'e'
  localparam logic [7:0] CH_UH   = 8'h48;  // 'H'
  localparam logic [7:0] CH_UI   = 8'h49;  // 'I'
  localparam logic [7:0] CH_LM   = 8'h6D;  // 'm'
  localparam logic [7:0] CH_UM   = 8'h4D;  // 'M'
  localparam logic [7:0] CH_US   = 8'h53;  // 'S'
  localparam logic [7:0] CH_UU   = 8'h55;  // 'U'
  localparam logic [7:0] CH_UW   = 8'h57;  // 'W'
  localparam logic [7:0] CH_LY   = 8'h79;  // 'y'

  // Controller to datapath
  typedef struct packed {
    logic cfg_wr;     // take a register write from the configuration port
    logic tmpl_wr;    // write template byte from the input transfer
    logic name_acc;   // take a name byte into the delay buffer
    logic feed_step;  // match the oldest buffered byte against the template
    logic rd_scan;    // template reads addressed by the format scan
    logic scan_init;  // start a format scan at the prefix end
    logic scan_step;  // evaluate one scan step
    logic out_load;   // load the result and clear the name state
  } tsm_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic buf_full;    // three bytes already wait in the delay buffer
    logic last_feeds;  // a final byte leaves at least one byte to match
    logic feed_final;  // the current feed step is the last one queued
    logic scan_end;    // the current scan step settles the format verdict
    logic fmt_stale;   // template or lengths changed since the last scan
    logic out_busy;    // result register still held by the consumer
  } tsm_status_t;

  // Digit count of a time specifier, zero when unknown
  function automatic logic [2:0] spec_digits(input logic [7:0] c);
    logic [2:0] n;
    case (c)
      CH_UY:   n = 3'd4;
      CH_LJ:   n = 3'd3;
      CH_UC, CH_LD, CH_LE, CH_UH, CH_UI, CH_LM,
      CH_UM, CH_US, CH_UU, CH_UW, CH_LY: n = 3'd2;
      default: n = 3'd0;
    endcase
    return n;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_0) && (c <= CH_9);
  endfunction

  // Length register clamped to the template depth
  function automatic logic [CLEN_W-1:0] clamp_len(input logic [CFG_W-1:0] v);
    return (int'(v) > TMPL_DEPTH) ? CLEN_W'(TMPL_DEPTH) : CLEN_W'(v);
  endfunction

endpackage
`default_nettype wire

/* src/tsm_ram.sv */
// Generic RAM: one write port, two registered read ports.
`default_nettype none
module tsm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr_a,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr_b,
  output logic      [WIDTH-1:0]         rd_data_a,
  output logic      [WIDTH-1:0]         rd_data_b
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_a <= mem_r[rd_addr_a];
    rd_data_b <= mem_r[rd_addr_b];
  end

endmodule
`default_nettype wire

/* src/tsm_ctrl.sv */
// Sequencer for template writes, name byte matching, format scan and result hand-off.
`default_nettype none
module tsm_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic                in_kind,
  input  wire logic                in_last,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire tsm_pkg::tsm_status_t st,
  output tsm_pkg::tsm_cmd_t        cmd
);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_FEED_RD = 3'd1;
  localparam logic [2:0] S_FEED_EV = 3'd2;
  localparam logic [2:0] S_SCAN_RD = 3'd3;
  localparam logic [2:0] S_SCAN_EV = 3'd4;
  localparam logic [2:0] S_DONE    = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic       last_r, last_nxt;

  // Next state and commands; register writes win over input transfers when idle
  always_comb begin
    state_nxt = state_r;
    last_nxt  = last_r;
    cmd       = '0;
    in_ready  = 1'b0;
    cfg_ready = 1'b0;
    case (state_r)
      S_IDLE: begin
        cfg_ready  = 1'b1;
        cmd.cfg_wr = cfg_valid;
        in_ready   = !cfg_valid;
        if (in_valid && !cfg_valid) begin
          if (in_kind == tsm_pkg::KIND_TMPL_WR) begin
            cmd.tmpl_wr = 1'b1;
          end else begin
            cmd.name_acc = 1'b1;
            last_nxt     = in_last;
            if (!in_last) begin
              if (st.buf_full) state_nxt = S_FEED_RD;
            end else if (st.last_feeds) begin
              state_nxt = S_FEED_RD;
            end else if (st.fmt_stale) begin
              cmd.scan_init = 1'b1;
              state_nxt     = S_SCAN_RD;
            end else begin
              state_nxt = S_DONE;
            end
          end
        end
      end
      S_FEED_RD: begin
        state_nxt = S_FEED_EV;
      end
      S_FEED_EV: begin
        cmd.feed_step = 1'b1;
        if (!st.feed_final) begin
          state_nxt = S_FEED_RD;
        end else if (!last_r) begin
          state_nxt = S_IDLE;
        end else if (st.fmt_stale) begin
          cmd.scan_init = 1'b1;
          state_nxt     = S_SCAN_RD;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_SCAN_RD: begin
        cmd.rd_scan = 1'b1;
        state_nxt   = S_SCAN_EV;
      end
      S_SCAN_EV: begin
        cmd.scan_step = 1'b1;
        state_nxt     = st.scan_end ? S_DONE : S_SCAN_RD;
      end
      S_DONE: begin
        if (!st.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      last_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      last_r  <= last_nxt;
    end
  end

  // A result is only loaded at the end of a final name byte
  a_load_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> last_r)
    else $error("result loaded without a final name byte");

  // A free result register lets the sequencer return to idle at once
  a_done_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && !st.out_busy) |=> state_r == S_IDLE)
    else $error("result hand-off stalled with a free output register");

endmodule
`default_nettype wire

/* src/tsm_dpath.sv */
// Datapath: delay buffer, template store, matcher state, format scan and result register.
`default_nettype none
module tsm_dpath (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire tsm_pkg::tsm_cmd_t            cmd,
  output tsm_pkg::tsm_status_t              st,
  input  wire logic [5:0]                   in_template_index,
  input  wire logic [7:0]                   in_template_char,
  input  wire logic [7:0]                   in_name_char,
  input  wire logic                         in_last,
  input  wire logic                         cfg_index,
  input  wire logic [tsm_pkg::CFG_W-1:0]    cfg_data,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic                              out_owned,
  output logic                              out_format_valid
);

  localparam int AW = tsm_pkg::TMPL_AW;
  localparam int CW = tsm_pkg::CLEN_W;

  // Configuration
  logic [tsm_pkg::CFG_W-1:0] prefix_len_r, tmpl_len_r;
  logic [CW-1:0]             pl, tl;

  // Name state
  logic [7:0]    buf_r [4];
  logic [1:0]    cnt_r;
  logic [2:0]    left_r;
  logic [CW-1:0] mp_r, mp_nxt;
  logic [2:0]    dl_r, dl_nxt;
  logic          mm_r, mm_nxt;

  // Format scan
  logic [CW-1:0] scan_i_r, scan_i_nxt;
  logic          has_r, has_nxt;
  logic          fmt_ok_r, fmt_ok_nxt;
  logic          stale_r;
  logic          scan_end;

  // Result register
  logic out_valid_r, out_owned_r, out_fmt_r;

  // Template store
  logic [CW-1:0] rd_base;
  logic [CW-1:0] rd_next;
  logic [7:0]    q0, q1;

  logic       strip;
  logic [2:0] use_cnt;
  logic [7:0] b;

  assign pl = tsm_pkg::clamp_len(prefix_len_r);
  assign tl = tsm_pkg::clamp_len(tmpl_len_r);

  assign rd_base = cmd.rd_scan ? scan_i_r : mp_r;
  assign rd_next = rd_base + CW'(1);

  tsm_ram #(
    .WIDTH (8),
    .DEPTH (tsm_pkg::TMPL_DEPTH)
  ) u_tmpl_ram (
    .clk       (clk),
    .wr_en     (cmd.tmpl_wr),
    .wr_addr   (AW'(in_template_index)),
    .wr_data   (in_template_char),
    .rd_addr_a (rd_base[AW-1:0]),
    .rd_addr_b (rd_next[AW-1:0]),
    .rd_data_a (q0),
    .rd_data_b (q1)
  );

  // Trailing ".7z" check over the buffered bytes plus the arriving one
  always_comb begin
    strip = 1'b0;
    if (cnt_r == 2'd2) begin
      strip = (buf_r[0] == tsm_pkg::CH_DOT) && (buf_r[1] == tsm_pkg::CH_7) &&
              (in_name_char == tsm_pkg::CH_Z);
    end else if (cnt_r == 2'd3) begin
      strip = (buf_r[1] == tsm_pkg::CH_DOT) && (buf_r[2] == tsm_pkg::CH_7) &&
              (in_name_char == tsm_pkg::CH_Z);
    end
    use_cnt = 3'(cnt_r) + 3'd1 - (strip ? 3'd3 : 3'd0);
  end

  // One match step on the oldest buffered byte
  assign b = buf_r[0];
  always_comb begin
    mp_nxt = mp_r;
    dl_nxt = dl_r;
    mm_nxt = mm_r;
    if (mm_r) begin
      mm_nxt = 1'b1;
    end else if (dl_r != 3'd0) begin
      if (!tsm_pkg::is_digit(b)) mm_nxt = 1'b1;
      dl_nxt = dl_r - 3'd1;
    end else if (mp_r >= tl) begin
      mm_nxt = 1'b1;
    end else if (mp_r < pl || q0 != tsm_pkg::CH_PCT) begin
      if (b != q0) mm_nxt = 1'b1;
      mp_nxt = mp_r + CW'(1);
    end else if (rd_next >= tl) begin
      mm_nxt = 1'b1;
    end else begin
      mp_nxt = mp_r + CW'(2);
      if (q1 == tsm_pkg::CH_PCT) begin
        if (b != tsm_pkg::CH_PCT) mm_nxt = 1'b1;
      end else if (tsm_pkg::spec_digits(q1) == 3'd0 || !tsm_pkg::is_digit(b)) begin
        mm_nxt = 1'b1;
      end else begin
        dl_nxt = tsm_pkg::spec_digits(q1) - 3'd1;
      end
    end
  end

  // One format scan step over the time format part
  always_comb begin
    scan_i_nxt = scan_i_r;
    has_nxt    = has_r;
    fmt_ok_nxt = fmt_ok_r;
    scan_end   = 1'b0;
    if (scan_i_r >= tl) begin
      scan_end   = 1'b1;
      fmt_ok_nxt = has_r;
    end else if (q0 != tsm_pkg::CH_PCT) begin
      scan_i_nxt = scan_i_r + CW'(1);
    end else if (scan_i_r + CW'(1) >= tl) begin
      scan_end   = 1'b1;
      fmt_ok_nxt = 1'b0;
    end else if (q1 != tsm_pkg::CH_PCT) begin
      if (tsm_pkg::spec_digits(q1) == 3'd0) begin
        scan_end   = 1'b1;
        fmt_ok_nxt = 1'b0;
      end else begin
        has_nxt    = 1'b1;
        scan_i_nxt = scan_i_r + CW'(2);
      end
    end else begin
      scan_i_nxt = scan_i_r + CW'(2);
    end
  end

  // Status to the controller
  always_comb begin
    st.buf_full   = (cnt_r == 2'd3);
    st.last_feeds = (use_cnt != 3'd0);
    st.feed_final = (left_r == 3'd1);
    st.scan_end   = scan_end;
    st.fmt_stale  = stale_r;
    st.out_busy   = out_valid_r && !out_ready;
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prefix_len_r <= '0;
      tmpl_len_r   <= '0;
      cnt_r        <= '0;
      left_r       <= '0;
      mp_r         <= '0;
      dl_r         <= '0;
      mm_r         <= 1'b0;
      stale_r      <= 1'b1;
      out_valid_r  <= 1'b0;
    end else begin
      if (cmd.cfg_wr) begin
        if (cfg_index == tsm_pkg::CFG_PREFIX_LEN) prefix_len_r <= cfg_data;
        else                                       tmpl_len_r   <= cfg_data;
      end
      if (cmd.cfg_wr || cmd.tmpl_wr) begin
        stale_r <= 1'b1;
      end else if (cmd.scan_step && scan_end) begin
        stale_r <= 1'b0;
      end
      if (cmd.name_acc) begin
        if (in_last)              left_r <= use_cnt;
        else if (cnt_r != 2'd3)   cnt_r  <= cnt_r + 2'd1;
        else                      left_r <= 3'd1;
      end
      if (cmd.feed_step) begin
        left_r <= left_r - 3'd1;
        mp_r   <= mp_nxt;
        dl_r   <= dl_nxt;
        mm_r   <= mm_nxt;
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
        cnt_r       <= '0;
        left_r      <= '0;
        mp_r        <= '0;
        dl_r        <= '0;
        mm_r        <= 1'b0;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.name_acc) begin
      buf_r[cnt_r] <= in_name_char;
    end
    if (cmd.feed_step) begin
      buf_r[0] <= buf_r[1];
      buf_r[1] <= buf_r[2];
      buf_r[2] <= buf_r[3];
    end
    if (cmd.scan_init) begin
      scan_i_r <= pl;
      has_r    <= 1'b0;
    end
    if (cmd.scan_step) begin
      scan_i_r <= scan_i_nxt;
      has_r    <= has_nxt;
      fmt_ok_r <= fmt_ok_nxt;
    end
    if (cmd.out_load) begin
      out_owned_r <= fmt_ok_r && !mm_r && (dl_r == 3'd0) && (mp_r == tl);
      out_fmt_r   <= fmt_ok_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_owned        = out_owned_r;
  assign out_format_valid = out_fmt_r;

  // The format verdict must be fresh when a result is loaded
  a_fresh_fmt: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> !stale_r)
    else $error("result loaded with a stale format verdict");

  // Specifier digit count stays within the widest specifier
  a_dl_range: assert property (@(posedge clk) disable iff (!rst_n)
    dl_r <= 3'd3)
    else $error("digit count out of range");

  // At most four buffered bytes are ever queued for matching
  a_left_range: assert property (@(posedge clk) disable iff (!rst_n)
    left_r <= 3'd4)
    else $error("feed count out of range");

  // The match position never runs past the template
  a_mp_range: assert property (@(posedge clk) disable iff (!rst_n)
    int'(mp_r) <= tsm_pkg::TMPL_DEPTH)
    else $error("match position beyond template depth");

endmodule
`default_nettype wire

/* src/timestamp_name_matcher.sv */
// Top level: matches streamed names against a prefix-plus-time-format template.
// Template writes, register writes and buffered name bytes are taken only when idle.
// Name byte with a full ".7z" delay buffer: one template read/evaluate pair.
// Final byte: a read/evaluate pair per matched byte (up to 4), plus a pair per format scan step
//   (at most the format length + 1) after a template or length change, plus any result stall.
// Reset (synchronous, active low) clears lengths and name state and marks the format unscanned;
//   template contents are undefined until written.
`default_nettype none
module timestamp_name_matcher (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic                      in_kind,
  input  wire logic [5:0]                in_template_index,
  input  wire logic [7:0]                in_template_char,
  input  wire logic [7:0]                in_name_char,
  input  wire logic                      in_last,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic                           out_owned,
  output logic                           out_format_valid,
  input  wire logic                      cfg_valid,
  output logic                           cfg_ready,
  input  wire logic                      cfg_index,
  input  wire logic [tsm_pkg::CFG_W-1:0] cfg_data
);

  tsm_pkg::tsm_cmd_t    cmd;
  tsm_pkg::tsm_status_t st;

  // Register writes are taken only while the sequencer is idle
  tsm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_kind   (in_kind),
    .in_last   (in_last),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .st        (st),
    .cmd       (cmd)
  );

  tsm_dpath u_dpath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .st                (st),
    .in_template_index (in_template_index),
    .in_template_char  (in_template_char),
    .in_name_char      (in_name_char),
    .in_last           (in_last),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_owned         (out_owned),
    .out_format_valid  (out_format_valid)
  );

endmodule
`default_nettype wire

/* tb/timestamp_name_matcher_test.sv */
// Self-checking testbench for timestamp_name_matcher: directed and random names against templates.
`timescale 1ns / 1ps

typedef struct packed {
  logic owned;
  logic fmt_ok;
} verdict_t;

// Ownership predictor and store of verdicts still due from the block
class ownership_board;
  logic [7:0] tmpl [tsm_pkg::TMPL_DEPTH];
  logic [7:0] held [3];
  int         held_cnt;
  int         pos;
  int         digits_to_go;
  bit         broken;
  logic [tsm_pkg::CFG_W-1:0] prefix_reg = '0;
  logic [tsm_pkg::CFG_W-1:0] tmpl_len_reg = '0;
  verdict_t   verdicts_due [$];
  int         fail_count;

  function int eff_len(logic [tsm_pkg::CFG_W-1:0] v);
    return (int'(v) > tsm_pkg::TMPL_DEPTH) ? tsm_pkg::TMPL_DEPTH : int'(v);
  endfunction

  // digits consumed by a time specifier, 0 for an unknown one
  function int spec_width(logic [7:0] c);
    case (c)
      tsm_pkg::CH_UY: return 4;
      tsm_pkg::CH_LJ: return 3;
      tsm_pkg::CH_UC, tsm_pkg::CH_LD, tsm_pkg::CH_LE, tsm_pkg::CH_UH, tsm_pkg::CH_UI,
      tsm_pkg::CH_LM, tsm_pkg::CH_UM, tsm_pkg::CH_US, tsm_pkg::CH_UU, tsm_pkg::CH_UW,
      tsm_pkg::CH_LY:
        return 2;
      default: return 0;
    endcase
  endfunction

  function bit digit(logic [7:0] c);
    return (c >= tsm_pkg::CH_0) && (c <= tsm_pkg::CH_9);
  endfunction

  // match one name byte that has left the delay buffer
  function void match_byte(logic [7:0] b);
    int tl;
    int pl;
    logic [7:0] c;
    tl = eff_len(tmpl_len_reg);
    pl = eff_len(prefix_reg);
    if (broken) return;
    if (digits_to_go > 0) begin
      if (!digit(b)) broken = 1'b1;
      digits_to_go--;
      return;
    end
    if (pos >= tl) begin
      broken = 1'b1;
      return;
    end
    c = tmpl[pos];
    // prefix bytes and plain format bytes match themselves
    if (pos < pl || c != tsm_pkg::CH_PCT) begin
      if (b != c) broken = 1'b1;
      pos++;
      return;
    end
    if (pos + 1 >= tl) begin
      broken = 1'b1;
      return;
    end
    c = tmpl[pos + 1];
    pos += 2;
    if (c == tsm_pkg::CH_PCT) begin
      if (b != tsm_pkg::CH_PCT) broken = 1'b1;
      return;
    end
    if (spec_width(c) == 0 || !digit(b)) begin
      broken = 1'b1;
      return;
    end
    digits_to_go = spec_width(c) - 1;
  endfunction

  // format part is usable for rotation: no stray %, no unknown specifier, one specifier at least
  function bit format_ok();
    int tl;
    int i;
    bit has_spec;
    tl = eff_len(tmpl_len_reg);
    i = eff_len(prefix_reg);
    has_spec = 1'b0;
    while (i < tl) begin
      if (tmpl[i] != tsm_pkg::CH_PCT) begin
        i++;
        continue;
      end
      i++;
      if (i >= tl) return 1'b0;
      if (tmpl[i] != tsm_pkg::CH_PCT) begin
        if (spec_width(tmpl[i]) == 0) return 1'b0;
        has_spec = 1'b1;
      end
      i++;
    end
    return has_spec;
  endfunction

  function void set_reg(logic idx, logic [tsm_pkg::CFG_W-1:0] val);
    if (idx == tsm_pkg::CFG_PREFIX_LEN) prefix_reg = val;
    else tmpl_len_reg = val;
  endfunction

  // note an accepted input transfer and queue the verdict it causes, if any
  function void take_item(logic kind, logic [5:0] idx, logic [7:0] tch, logic [7:0] nch,
                          logic last);
    logic [7:0] tail [4];
    int n;
    int use_n;
    int k;
    verdict_t v;
    if (kind == tsm_pkg::KIND_TMPL_WR) begin
      tmpl[idx] = tch;
      return;
    end
    if (!last) begin
      if (held_cnt < 3) begin
        held[held_cnt] = nch;
        held_cnt++;
      end else begin
        match_byte(held[0]);
        held[0] = held[1];
        held[1] = held[2];
        held[2] = nch;
      end
      return;
    end
    // final byte: flush the buffer, dropping a trailing .7z
    for (k = 0; k < held_cnt; k++) tail[k] = held[k];
    tail[held_cnt] = nch;
    n = held_cnt + 1;
    use_n = n;
    if (n >= 3 && tail[n-3] == tsm_pkg::CH_DOT && tail[n-2] == tsm_pkg::CH_7 &&
        tail[n-1] == tsm_pkg::CH_Z)
      use_n = n - 3;
    for (k = 0; k < use_n; k++) match_byte(tail[k]);
    v.fmt_ok = format_ok();
    v.owned  = v.fmt_ok && !broken && digits_to_go == 0 && pos == eff_len(tmpl_len_reg);
    verdicts_due = {verdicts_due, v};
    held_cnt = 0;
    pos = 0;
    digits_to_go = 0;
    broken = 1'b0;
  endfunction

  task report(string msg);
    fail_count++;
    $display("[%0t] MISMATCH: %s", $time, msg);
  endtask

  task check_verdict(logic owned, logic fmt_valid);
    verdict_t v;
    if (verdicts_due.size() == 0) begin
      report($sformatf("result with none due: owned=%0b format_valid=%0b", owned, fmt_valid));
      return;
    end
    v = verdicts_due.pop_front();
    if (owned !== v.owned)
      report($sformatf("owned got %0b expected %0b", owned, v.owned));
    if (fmt_valid !== v.fmt_ok)
      report($sformatf("format_valid got %0b expected %0b", fmt_valid, v.fmt_ok));
  endtask
endclass

module timestamp_name_matcher_test;

  localparam int RANDOM_ITEMS = 600;
  localparam int SETTLE_CYCLES = 300;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic             in_kind = tsm_pkg::KIND_NAME;
  logic [5:0]       in_template_index = '0;
  logic [7:0]       in_template_char = '0;
  logic [7:0]       in_name_char = '0;
  logic             in_last = 1'b0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic             out_owned;
  logic             out_format_valid;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic             cfg_index = tsm_pkg::CFG_PREFIX_LEN;
  logic [tsm_pkg::CFG_W-1:0] cfg_data = '0;

  ownership_board board;
  logic [7:0]     tmpl_shadow [tsm_pkg::TMPL_DEPTH];
  logic [7:0]     tmpl_buf [$];
  logic [7:0]     name_buf [$];
  int             cur_pl;
  int             cur_tl;
  int             items_sent;
  int             send_gap_pct = 18;
  int             recv_stall_pct = 88;

  timestamp_name_matcher dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_kind          (in_kind),
    .in_template_index(in_template_index),
    .in_template_char (in_template_char),
    .in_name_char     (in_name_char),
    .in_last          (in_last),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_owned        (out_owned),
    .out_format_valid (out_format_valid),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // receiver back-pressure
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // monitor: results are checked before the same edge's input can queue a verdict
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) board.check_verdict(out_owned, out_format_valid);
      if (cfg_valid && cfg_ready) board.set_reg(cfg_index, cfg_data);
      if (in_valid && in_ready)
        board.take_item(in_kind, in_template_index, in_template_char, in_name_char, in_last);
    end
  end

  // append to the template and name staging queues
  function automatic void add_tmpl(logic [7:0] c);
    tmpl_buf = {tmpl_buf, c};
  endfunction

  function automatic void add_name(logic [7:0] c);
    name_buf = {name_buf, c};
  endfunction

  // one input transfer; valid is left high so a following item goes back to back
  task automatic push_item(logic kind, logic [5:0] idx, logic [7:0] tch, logic [7:0] nch,
                           logic last);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid          = 1'b1;
    in_kind           = kind;
    in_template_index = idx;
    in_template_char  = tch;
    in_name_char      = nch;
    in_last           = last;
    do @(posedge clk); while (!in_ready);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic write_tmpl(logic [5:0] idx, logic [7:0] ch);
    push_item(tsm_pkg::KIND_TMPL_WR, idx, ch, 8'($urandom_range(255)), 1'($urandom_range(1)));
    tmpl_shadow[idx] = ch;
  endtask

  // both length registers, two transfers on the configuration port
  task automatic set_lengths(int pl, int tl);
    cfg_valid = 1'b1;
    cfg_index = tsm_pkg::CFG_PREFIX_LEN;
    cfg_data  = tsm_pkg::CFG_W'(pl);
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_index = tsm_pkg::CFG_TEMPLATE_LEN;
    cfg_data  = tsm_pkg::CFG_W'(tl);
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
    cur_pl = pl;
    cur_tl = tl;
  endtask

  // wait for every verdict, then let any trailing match work finish
  task automatic settle();
    in_valid = 1'b0;
    while (board.verdicts_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic load_text(string s);
    int k;
    name_buf.delete();
    for (k = 0; k < s.len(); k++) add_name(s[k]);
  endtask

  // stream name_buf, now and then slipping a template write between bytes
  task automatic send_name(int interrupt_pct);
    int k;
    for (k = 0; k < name_buf.size(); k++) begin
      if (k > 0 && $urandom_range(99) < interrupt_pct)
        write_tmpl(6'($urandom_range(63)), 8'($urandom_range(255)));
      push_item(tsm_pkg::KIND_NAME, 6'($urandom_range(63)), 8'($urandom_range(255)),
                name_buf[k], k == name_buf.size() - 1);
    end
  endtask

  // one random setting: lengths, template, then a batch of names
  task automatic random_phase();
    int pl;
    int tl;
    int i;
    int n;
    int nm;
    bit plain;
    logic [7:0] c;
    settle();
    tmpl_buf.delete();
    pl = ($urandom_range(9) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 6);
    repeat (pl) begin
      c = ($urandom_range(7) == 0) ? tsm_pkg::CH_PCT : 8'($urandom_range(255));
      add_tmpl(c);
    end
    // format: specifiers, %%, unknown specifiers and literals
    plain = ($urandom_range(9) == 0);
    repeat ($urandom_range(1, 6)) begin
      case (plain ? 9 : $urandom_range(9))
        0, 1, 2, 3: begin
          case ($urandom_range(12))
            0: c = tsm_pkg::CH_UY;
            1: c = tsm_pkg::CH_LJ;
            2: c = tsm_pkg::CH_UC;
            3: c = tsm_pkg::CH_LD;
            4: c = tsm_pkg::CH_LE;
            5: c = tsm_pkg::CH_UH;
            6: c = tsm_pkg::CH_UI;
            7: c = tsm_pkg::CH_LM;
            8: c = tsm_pkg::CH_UM;
            9: c = tsm_pkg::CH_US;
            10: c = tsm_pkg::CH_UU;
            11: c = tsm_pkg::CH_UW;
            default: c = tsm_pkg::CH_LY;
          endcase
          add_tmpl(tsm_pkg::CH_PCT);
          add_tmpl(c);
        end
        4: begin
          add_tmpl(tsm_pkg::CH_PCT);
          add_tmpl(tsm_pkg::CH_PCT);
        end
        5: begin
          do c = 8'($urandom_range(255));
          while (c == tsm_pkg::CH_PCT || board.spec_width(c) != 0);
          add_tmpl(tsm_pkg::CH_PCT);
          add_tmpl(c);
        end
        default: begin
          do c = 8'($urandom_range(255)); while (c == tsm_pkg::CH_PCT);
          add_tmpl(c);
        end
      endcase
    end
    if ($urandom_range(19) == 0) add_tmpl(tsm_pkg::CH_PCT);
    tl = tmpl_buf.size();
    case ($urandom_range(19))
      0: tl = $urandom_range(0, 127);
      1: pl = $urandom_range(0, 127);
      2: tl = 127;
      3: pl = tl;
      default: ;
    endcase
    set_lengths(pl, tl);
    for (i = 0; i < tmpl_buf.size(); i++) write_tmpl(6'(i), tmpl_buf[i]);

    for (nm = 0; nm < 8; nm++) begin
      name_buf.delete();
      if ($urandom_range(3) != 0) begin
        // well-formed name built from the template as it now stands
        tl = board.eff_len(tsm_pkg::CFG_W'(cur_tl));
        pl = board.eff_len(tsm_pkg::CFG_W'(cur_pl));
        i = 0;
        while (i < tl) begin
          c = tmpl_shadow[i];
          if (i < pl || c != tsm_pkg::CH_PCT) begin
            add_name(c);
            i++;
          end else if (i + 1 >= tl) begin
            add_name(tsm_pkg::CH_PCT);
            i++;
          end else begin
            c = tmpl_shadow[i + 1];
            n = board.spec_width(c);
            if (c == tsm_pkg::CH_PCT) add_name(tsm_pkg::CH_PCT);
            else if (n == 0) add_name(8'($urandom_range(255)));
            else repeat (n) add_name(8'(tsm_pkg::CH_0 + $urandom_range(9)));
            i += 2;
          end
        end
        if (name_buf.size() == 0) add_name(8'($urandom_range(255)));
        if ($urandom_range(1) == 0) begin
          add_name(tsm_pkg::CH_DOT);
          add_name(tsm_pkg::CH_7);
          add_name(tsm_pkg::CH_Z);
        end
        // broken variants: changed, dropped, extra or cut short
        if ($urandom_range(3) == 0) begin
          i = $urandom_range(name_buf.size() - 1);
          case ($urandom_range(3))
            0: name_buf[i] = 8'($urandom_range(255));
            1: if (name_buf.size() > 1) name_buf.delete(i);
            2: name_buf.insert(i, 8'($urandom_range(255)));
            default: while (name_buf.size() > i + 1) void'(name_buf.pop_back());
          endcase
        end
      end else begin
        // noise, heavy on digits
        repeat ($urandom_range(1, 8))
          add_name(($urandom_range(1) == 0) ? 8'(tsm_pkg::CH_0 + $urandom_range(9))
                                            : 8'($urandom_range(255)));
        if ($urandom_range(4) == 0) begin
          add_name(tsm_pkg::CH_DOT);
          add_name(tsm_pkg::CH_7);
          add_name(tsm_pkg::CH_Z);
        end
      end
      send_name(3);
    end
  endtask

  initial begin
    int k;
    int start_items;
    board = new;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // load every template entry so no read ever lands on an unwritten one
    for (k = 0; k < tsm_pkg::TMPL_DEPTH; k++) write_tmpl(6'(k), 8'($urandom_range(255)));

    // empty format, and a bare .7z stripped to nothing
    settle();
    set_lengths(0, 0);
    load_text("x");
    send_name(0);
    load_text(".7z");
    send_name(0);

    // two-digit year: stripped suffix, then a short name with a non-digit
    write_tmpl(6'd0, tsm_pkg::CH_PCT);
    write_tmpl(6'd1, tsm_pkg::CH_LY);
    settle();
    set_lengths(0, 2);
    load_text("07.7z");
    send_name(0);
    load_text("9x");
    send_name(0);

    // template rewritten to a four-digit year while a name is in flight
    push_item(tsm_pkg::KIND_NAME, 6'd0, 8'd0, 8'(tsm_pkg::CH_0 + 8'd1), 1'b0);
    write_tmpl(6'd1, tsm_pkg::CH_UY);
    load_text("234");
    send_name(0);

    // percent inside the prefix is literal, leaving a format with no specifier
    settle();
    set_lengths(1, 2);
    load_text("%Y");
    send_name(0);

    // trailing percent in the format
    write_tmpl(6'd2, tsm_pkg::CH_PCT);
    settle();
    set_lengths(0, 3);
    load_text("1");
    send_name(0);

    // both lengths saturate, prefix covers the whole template
    settle();
    set_lengths(64, 127);
    load_text(".7z");
    send_name(0);

    // full-depth format
    settle();
    set_lengths(0, 64);
    load_text("a");
    send_name(0);

    // random settings; idling pattern changes each third of the run
    start_items = items_sent;
    while (items_sent - start_items < RANDOM_ITEMS) begin
      case ((items_sent - start_items) * 3 / RANDOM_ITEMS)
        0: begin
          send_gap_pct = 18;
          recv_stall_pct = 88;
        end
        1: begin
          send_gap_pct = 88;
          recv_stall_pct = 18;
        end
        default: begin
          send_gap_pct = 0;
          recv_stall_pct = 0;
        end
      endcase
      random_phase();
    end

    settle();
    if (board.fail_count == 0 && board.verdicts_due.size() == 0)
      $display("timestamp_name_matcher verification clean");
    else
      $display("timestamp_name_matcher verification failed");
    $finish;
  end

  // watchdog
  initial begin
    #1500000;
    $display("timestamp_name_matcher verification failed");
    $finish;
  end

endmodule
